// File: design/agb_pkg.sv
// Shared types and constants for the antialiased glyph blitter.
// Holds the register map, the configuration bundle and the front-to-back queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package agb_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
    localparam logic [2:0] REG_BOX_WIDTH      = 3'd2;
    localparam logic [2:0] REG_BOX_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_BYTES_PER_LINE = 3'd4;
    localparam logic [2:0] REG_FG_COLOR       = 3'd5;
    localparam logic [2:0] REG_BG_COLOR       = 3'd6;

    // Reset values of the registers
    localparam logic [9:0]  RST_ORIGIN_X       = 10'd50;
    localparam logic [9:0]  RST_ORIGIN_Y       = 10'd50;
    localparam logic [7:0]  RST_BOX_WIDTH      = 8'd11;
    localparam logic [7:0]  RST_BOX_HEIGHT     = 8'd14;
    localparam logic [5:0]  RST_BYTES_PER_LINE = 6'd3;
    localparam logic [15:0] RST_FG_COLOR       = 16'hFFFF;
    localparam logic [15:0] RST_BG_COLOR       = 16'h0000;

    // Pixels per bitmap byte and queue depth
    localparam int unsigned PIX_PER_BYTE = 4;
    localparam int unsigned QUEUE_DEPTH  = 2;

    // Blend weights in percent and the reciprocal of 100 as 5243 / 2^19
    localparam logic [6:0]  WEIGHT_MID_BG = 7'd33;
    localparam logic [6:0]  WEIGHT_MID_FG = 7'd67;
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int unsigned RECIP_SHIFT   = 19;

    // Configuration bundle
    typedef struct packed {
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [7:0]  box_width;
        logic [7:0]  box_height;
        logic [5:0]  bytes_per_line;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } agb_cfg_t;

    // One classified byte: per pixel its write flag, position and gray level
    typedef struct packed {
        logic [PIX_PER_BYTE-1:0]      wr;
        logic [PIX_PER_BYTE-1:0][7:0] col;
        logic [PIX_PER_BYTE-1:0][7:0] row;
        logic [PIX_PER_BYTE-1:0][1:0] lvl;
        logic                         done;
    } agb_entry_t;

endpackage

`default_nettype wire

// File: design/agb_front.sv
// Front end of the glyph blitter: accepts bitmap bytes and walks the column/row counters.
// Classifies each of the four pixels of a byte into a queue entry.
// Depends on agb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agb_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire agb_pkg::agb_cfg_t cfg,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [7:0]           s_tdata,     // [7:0] glyph_byte
    input  wire                  q_full,
    output logic                 push,
    output agb_pkg::agb_entry_t  entry
);

    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [7:0] row_len;
    logic       accept;

    assign row_len  = {cfg.bytes_per_line, 2'b00};
    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Step the counters over the four pixels of the byte
    always_comb begin
        logic [7:0] col;
        logic [7:0] row;
        col = col_reg;
        row = row_reg;
        entry.done = 1'b0;
        for (int i = 0; i < agb_pkg::PIX_PER_BYTE; i++) begin
            entry.col[i] = col;
            entry.row[i] = row;
            entry.wr[i]  = (col < cfg.box_width);
            entry.lvl[i] = s_tdata[7 - 2*i -: 2];
            col = col + 8'd1;
            if (col == row_len) begin
                col = 8'd0;
                row = row + 8'd1;
                if (row == cfg.box_height) begin
                    row = 8'd0;
                    entry.done = 1'b1;
                end
            end
        end
        col_next = col;
        row_next = row;
    end

    // Drop bytes that cause no result
    assign push = accept && ((|entry.wr) || entry.done);

    // Advance the counters on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 8'd0;
            row_reg <= 8'd0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: design/agb_queue.sv
// Short register queue between the front and back of the glyph blitter.
// Holds classified byte entries so either side can stall on its own.
// Depends on agb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agb_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire agb_pkg::agb_entry_t push_entry,
    output logic                full,
    input  wire                 pop,
    output logic                head_valid,
    output agb_pkg::agb_entry_t head_entry
);

    localparam int unsigned PTR_W = $clog2(agb_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(agb_pkg::QUEUE_DEPTH + 1);

    agb_pkg::agb_entry_t entry_q [agb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(agb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_q[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(agb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(agb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_q[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: design/agb_back.sv
// Back end of the glyph blitter: turns queue entries into framebuffer writes.
// Emits one pixel write or glyph-end marker per cycle through an output register while the sink is ready.
// Depends on agb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agb_back #(
    parameter int COORD_BITS = 10
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire agb_pkg::agb_cfg_t cfg,
    input  wire                 head_valid,
    input  wire agb_pkg::agb_entry_t head_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [39:0]         m_tdata,   // [9:0] pix_x, [19:10] pix_y, [35:20] pixel_color
    output logic                m_tlast,   // last
    output logic [1:0]          m_tuser    // [0] write_enable, [1] glyph_done
);

    localparam logic [10:0] COORD_MASK = 11'((1 << COORD_BITS) - 1);

    logic [3:0]  used_reg, used_next;
    logic [3:0]  pending, rest, sel_bit;
    logic [1:0]  sel_idx;
    logic        load;
    logic [10:0] sum_x, sum_y;
    logic [15:0] mid_color, pix_color;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    // Pick the first pixel still owed by the head entry
    assign pending = head_entry.wr & ~used_reg;
    always_comb begin
        sel_idx = 2'd0;
        for (int i = agb_pkg::PIX_PER_BYTE - 1; i >= 0; i--) begin
            if (pending[i]) begin
                sel_idx = 2'(i);
            end
        end
    end
    assign sel_bit = 4'b0001 << sel_idx;
    assign rest    = pending & ~sel_bit;
    assign load    = head_valid && (!m_tvalid_reg || m_tready);
    assign pop     = load && (rest == 4'd0);

    always_comb begin
        used_next = used_reg;
        if (load) begin
            used_next = pop ? 4'd0 : (used_reg | sel_bit);
        end
    end

    // Blend one channel at 33 percent background
    function automatic logic [5:0] blend_mid(input logic [5:0] bg, input logic [5:0] fg);
        logic [12:0] v;
        logic [25:0] prod;
        v    = 13'(bg) * 13'(agb_pkg::WEIGHT_MID_BG) + 13'(fg) * 13'(agb_pkg::WEIGHT_MID_FG);
        prod = 26'(v) * 26'(agb_pkg::RECIP_100);
        return prod[agb_pkg::RECIP_SHIFT +: 6];
    endfunction

    always_comb begin
        logic [5:0] r6, g6, b6;
        r6 = blend_mid({1'b0, cfg.bg_color[15:11]}, {1'b0, cfg.fg_color[15:11]});
        g6 = blend_mid(cfg.bg_color[10:5], cfg.fg_color[10:5]);
        b6 = blend_mid({1'b0, cfg.bg_color[4:0]}, {1'b0, cfg.fg_color[4:0]});
        mid_color = {r6[4:0], g6, b6[4:0]};
    end

    // Select the color by gray level
    always_comb begin
        case (head_entry.lvl[sel_idx])
            2'd0:    pix_color = cfg.fg_color;
            2'd3:    pix_color = cfg.bg_color;
            default: pix_color = mid_color;
        endcase
    end

    // Wrap coordinates to the coordinate width
    assign sum_x = (11'(cfg.origin_x) + 11'(head_entry.col[sel_idx])) & COORD_MASK;
    assign sum_y = (11'(cfg.origin_y) + 11'(head_entry.row[sel_idx])) & COORD_MASK;

    // Build the next result: pixel write, or a bare glyph-end marker
    always_comb begin
        if (pending != 4'd0) begin
            m_tdata_next = {4'd0, pix_color, sum_y[9:0], sum_x[9:0]};
            m_tuser_next = {head_entry.done, 1'b1};
        end else begin
            m_tdata_next = 40'd0;
            m_tuser_next = {head_entry.done, 1'b0};
        end
        m_tlast_next = (rest == 4'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold the payload until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= m_tlast_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: design/antialiased_glyph_blitter_top.sv
// Path: an accepted byte is stored in the queue, then its results pass the output register.
// Throughput: one byte per cycle into a two-entry queue while it has room; the back end
// emits one result per cycle while the sink is ready, so a byte holds it until all of its
// results (up to 4) are out, and a byte that causes no result is dropped in the front.
// Reset: aresetn, synchronous, active low; clears counters, queue, output valid
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module antialiased_glyph_blitter_top #(
    parameter int COORD_BITS = 10
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] glyph_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,    // [9:0] pix_x, [19:10] pix_y, [35:20] pixel_color
    output logic        m_tlast,    // last
    output logic [1:0]  m_tuser     // [0] write_enable, [1] glyph_done
);

    agb_pkg::agb_cfg_t   cfg_reg;
    agb_pkg::agb_entry_t push_entry, head_entry;
    logic                push, q_full, pop, head_valid;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x       <= agb_pkg::RST_ORIGIN_X;
            cfg_reg.origin_y       <= agb_pkg::RST_ORIGIN_Y;
            cfg_reg.box_width      <= agb_pkg::RST_BOX_WIDTH;
            cfg_reg.box_height     <= agb_pkg::RST_BOX_HEIGHT;
            cfg_reg.bytes_per_line <= agb_pkg::RST_BYTES_PER_LINE;
            cfg_reg.fg_color       <= agb_pkg::RST_FG_COLOR;
            cfg_reg.bg_color       <= agb_pkg::RST_BG_COLOR;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                agb_pkg::REG_ORIGIN_X:       cfg_reg.origin_x       <= cfg_data[9:0];
                agb_pkg::REG_ORIGIN_Y:       cfg_reg.origin_y       <= cfg_data[9:0];
                agb_pkg::REG_BOX_WIDTH:      cfg_reg.box_width      <= cfg_data[7:0];
                agb_pkg::REG_BOX_HEIGHT:     cfg_reg.box_height     <= cfg_data[7:0];
                agb_pkg::REG_BYTES_PER_LINE: cfg_reg.bytes_per_line <= cfg_data[5:0];
                agb_pkg::REG_FG_COLOR:       cfg_reg.fg_color       <= cfg_data;
                agb_pkg::REG_BG_COLOR:       cfg_reg.bg_color       <= cfg_data;
                default: ;
            endcase
        end
    end

    agb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .entry    (push_entry)
    );

    agb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    agb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// File: sim/antialiased_glyph_blitter_top_tb.sv
// Self-checking testbench for antialiased_glyph_blitter_top.
// Streams glyph bytes, predicts every framebuffer write and glyph-end marker, and
// checks each m_ item against it. Depends on agb_pkg and the top level.
`timescale 1ns / 1ps

module antialiased_glyph_blitter_top_tb;

    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int unsigned FULL_WEIGHT = 100;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;
    localparam longint unsigned TIMEOUT_NS = 10_000_000;

    // One predicted item on the result stream
    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [15:0] color;
        logic        we;
        logic        last;
        logic        done;
    } pixel_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = agb_pkg::REG_ORIGIN_X;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;    // [9:0] pix_x, [19:10] pix_y, [35:20] pixel_color
    logic        m_tlast;    // last
    logic [1:0]  m_tuser;    // [0] write_enable, [1] glyph_done

    // Predictor state: register copy and the glyph walk counters
    agb_pkg::agb_cfg_t regs;
    logic [7:0]        col_pos;
    logic [7:0]        row_pos;
    pixel_write_t      pending_writes[$];

    int unsigned failures = 0;
    bit          idle_gaps = 1'b0;
    bit          sink_stalls = 1'b0;

    antialiased_glyph_blitter_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Blend one gray level between foreground and background, channel by channel
    function automatic logic [15:0] blend_level(input logic [1:0] lvl);
        int unsigned w;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        w = (lvl == 2'd0) ? 0
                          : ((lvl == 2'd3) ? FULL_WEIGHT : int'(agb_pkg::WEIGHT_MID_BG));
        r = (regs.bg_color[15:11] * w + regs.fg_color[15:11] * (FULL_WEIGHT - w))
            / FULL_WEIGHT;
        g = (regs.bg_color[10:5] * w + regs.fg_color[10:5] * (FULL_WEIGHT - w))
            / FULL_WEIGHT;
        b = (regs.bg_color[4:0] * w + regs.fg_color[4:0] * (FULL_WEIGHT - w))
            / FULL_WEIGHT;
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    // Walk the four pixels of one byte and queue the writes it causes
    task automatic predict_glyph_byte(input logic [7:0] glyph);
        pixel_write_t res[$];
        pixel_write_t one;
        logic [7:0]   row_len;
        logic [1:0]   lvl;
        logic         ended;
        ended = 1'b0;
        row_len = {regs.bytes_per_line, 2'b00};
        for (int p = 0; p < 4; p++) begin
            lvl = glyph[7 - 2 * p -: 2];
            if (col_pos < regs.box_width) begin
                one.x = 10'(regs.origin_x + 10'(col_pos));
                one.y = 10'(regs.origin_y + 10'(row_pos));
                one.color = blend_level(lvl);
                one.we = 1'b1;
                one.last = 1'b0;
                one.done = 1'b0;
                res.push_back(one);
            end
            col_pos = col_pos + 8'd1;
            if (col_pos == row_len) begin
                col_pos = '0;
                row_pos = row_pos + 8'd1;
                if (row_pos == regs.box_height) begin
                    row_pos = '0;
                    ended = 1'b1;
                end
            end
        end
        // A glyph that ends without a write still reports its end
        if (res.size() == 0 && ended) begin
            one = '0;
            res.push_back(one);
        end
        foreach (res[k]) res[k].done = ended;
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[k]) pending_writes.push_back(res[k]);
    endtask

    task automatic flag_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Compare each accepted item with the oldest prediction
    always @(posedge aclk) begin : check_results
        pixel_write_t got;
        pixel_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[9:0];
            got.y = m_tdata[19:10];
            got.color = m_tdata[35:20];
            got.we = m_tuser[0];
            got.last = m_tlast;
            got.done = m_tuser[1];
            if (pending_writes.size() == 0) begin
                flag_failure($sformatf("unexpected item x=%0d y=%0d c=%h we=%b last=%b done=%b",
                    got.x, got.y, got.color, got.we, got.last, got.done));
            end else begin
                want = pending_writes.pop_front();
                if (got !== want || m_tdata[39:36] !== 4'd0) begin
                    flag_failure($sformatf(
                        "exp x=%0d y=%0d c=%h we=%b last=%b done=%b, got x=%0d y=%0d c=%h we=%b last=%b done=%b pad=%h",
                        want.x, want.y, want.color, want.we, want.last, want.done,
                        got.x, got.y, got.color, got.we, got.last, got.done, m_tdata[39:36]));
                end
            end
        end
    end

    // Pace the result side: mostly ready, short stalls, a few long ones
    initial begin : sink_pacing
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_gaps || roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte, hold it until accepted, then predict its writes
    task automatic send_glyph_byte(input logic [7:0] glyph);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= glyph;
        do @(posedge aclk); while (!s_tready);
        predict_glyph_byte(glyph);
    endtask

    task automatic send_random_bytes(input int unsigned count);
        for (int i = 0; i < count; i++) send_glyph_byte(8'($urandom));
    endtask

    // Hold the sender until every predicted item has come and the pipe is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            agb_pkg::REG_ORIGIN_X:       regs.origin_x = value[9:0];
            agb_pkg::REG_ORIGIN_Y:       regs.origin_y = value[9:0];
            agb_pkg::REG_BOX_WIDTH:      regs.box_width = value[7:0];
            agb_pkg::REG_BOX_HEIGHT:     regs.box_height = value[7:0];
            agb_pkg::REG_BYTES_PER_LINE: regs.bytes_per_line = value[5:0];
            agb_pkg::REG_FG_COLOR:       regs.fg_color = value;
            agb_pkg::REG_BG_COLOR:       regs.bg_color = value;
            default: ;
        endcase
    endtask

    // Rewrite every register once the block is idle
    task automatic load_config(input logic [15:0] ox, input logic [15:0] oy,
                               input logic [15:0] bw, input logic [15:0] bh,
                               input logic [15:0] bpl, input logic [15:0] fg,
                               input logic [15:0] bg);
        wait_idle();
        write_reg(agb_pkg::REG_ORIGIN_X, ox);
        write_reg(agb_pkg::REG_ORIGIN_Y, oy);
        write_reg(agb_pkg::REG_BOX_WIDTH, bw);
        write_reg(agb_pkg::REG_BOX_HEIGHT, bh);
        write_reg(agb_pkg::REG_BYTES_PER_LINE, bpl);
        write_reg(agb_pkg::REG_FG_COLOR, fg);
        write_reg(agb_pkg::REG_BG_COLOR, bg);
        cfg_valid <= 1'b0;
    endtask

    // Reset values: 11 visible columns of a 12-pixel row
    task automatic test_default_glyph();
        send_glyph_byte(8'h00);
        send_glyph_byte(8'hFF);
        send_glyph_byte(8'h1B);
        send_glyph_byte(8'h55);
        send_glyph_byte(8'hAA);
        send_glyph_byte(8'hE4);
    endtask

    // Color and coordinate extremes, all four gray levels
    task automatic test_color_extremes();
        load_config(16'd1023, 16'd1023, 16'd8, 16'd2, 16'd2, 16'hFFFF, 16'h0000);
        send_glyph_byte(8'h1B);
        send_glyph_byte(8'hE4);
        load_config(16'd0, 16'd0, 16'd8, 16'd2, 16'd2, 16'h0000, 16'hFFFF);
        send_glyph_byte(8'h1B);
        send_glyph_byte(8'hE4);
        load_config(16'hFFFF, 16'hFC00, 16'd8, 16'd2, 16'd2, 16'hF800, 16'h07E0);
        send_glyph_byte(8'h1B);
        send_glyph_byte(8'h6C);
    endtask

    // Glyph end with no writes gives a lone marker; with writes it flags them
    task automatic test_glyph_end_marker();
        load_config(16'd100, 16'd200, 16'd0, 16'd1, 16'd1, 16'h1234, 16'hABCD);
        send_glyph_byte(8'h00);
        send_glyph_byte(8'hFF);
        send_glyph_byte(8'h93);
        load_config(16'd100, 16'd200, 16'd0, 16'd2, 16'd2, 16'h1234, 16'hABCD);
        repeat (4) send_glyph_byte(8'h5A);
        load_config(16'd5, 16'd6, 16'd2, 16'd1, 16'd1, 16'h07FF, 16'hF81F);
        send_glyph_byte(8'hC6);
        send_glyph_byte(8'h39);
    endtask

    // A write to the unused index leaves every register alone
    task automatic test_unmapped_index();
        wait_idle();
        write_reg(REG_UNMAPPED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_glyph_byte(8'hD2);
        send_glyph_byte(8'h2D);
    endtask

    // Zero bytes per line: rows run 256 pixels before the counter wraps
    task automatic test_wide_rows();
        idle_gaps = 1'b1;
        sink_stalls = 1'b1;
        load_config(16'd900, 16'd1000, 16'd255, 16'd1, 16'hFFC0, 16'($urandom),
                    16'($urandom));
        send_random_bytes(70);
    endtask

    // Zero box height: the glyph ends only after 256 rows
    task automatic test_tall_glyph();
        idle_gaps = 1'b0;
        sink_stalls = 1'b1;
        load_config(16'd1020, 16'd3, 16'($urandom_range(1, 4)), 16'hFF00, 16'd1,
                    16'($urandom), 16'($urandom));
        send_random_bytes(130);
        idle_gaps = 1'b1;
        send_random_bytes(130);
    endtask

    // Random settings per phase; counters carry over so changes land mid-glyph
    task automatic test_random_glyphs();
        logic [7:0] bw;
        logic [7:0] bh;
        logic [5:0] bpl;
        for (int phase = 0; phase < 6; phase++) begin
            idle_gaps = (phase != 0);
            sink_stalls = (phase != 0) && (phase != 3);
            bw = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 14));
            bh = 8'($urandom_range(0, 6));
            bpl = ($urandom_range(0, 4) == 0) ? 6'd63 : 6'($urandom_range(1, 3));
            load_config(16'($urandom), 16'($urandom), {8'($urandom), bw},
                        {8'($urandom), bh}, {10'($urandom), bpl},
                        16'($urandom), 16'($urandom));
            send_random_bytes(10);
            // Let the result side run dry before going on
            wait_idle();
            send_random_bytes(10);
        end
    endtask

    initial begin
        regs.origin_x = agb_pkg::RST_ORIGIN_X;
        regs.origin_y = agb_pkg::RST_ORIGIN_Y;
        regs.box_width = agb_pkg::RST_BOX_WIDTH;
        regs.box_height = agb_pkg::RST_BOX_HEIGHT;
        regs.bytes_per_line = agb_pkg::RST_BYTES_PER_LINE;
        regs.fg_color = agb_pkg::RST_FG_COLOR;
        regs.bg_color = agb_pkg::RST_BG_COLOR;
        col_pos = '0;
        row_pos = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_glyph();
        test_color_extremes();
        test_glyph_end_marker();
        test_unmapped_index();
        test_wide_rows();
        test_tall_glyph();
        test_random_glyphs();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
